### rtl/qac_pkg.sv
`default_nettype none

package qac_pkg;

  // Class configuration: number of classes in use and slots addressable by class_id
  localparam int NumClasses = 4;
  localparam int ClassIdW   = 2;
  localparam int ClassSlots = 2 ** ClassIdW;

  // Counter width and saturation point
  localparam int CntW = 16;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Configuration register index width and data width
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [1:0] {
    KindRequest    = 2'd0,
    KindRelease    = 2'd1,
    KindClassReset = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RefNone   = 2'd0,
    RefTotal  = 2'd1,
    RefActive = 2'd2,
    RefClass  = 2'd3
  } refusal_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxActive   = 3'd0,
    CfgMaxTotal    = 3'd1,
    CfgClassEnable = 3'd2,
    CfgClassLimit0 = 3'd3,
    CfgClassLimit1 = 3'd4,
    CfgClassLimit2 = 3'd5,
    CfgClassLimit3 = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    kind_e               kind;
    logic [ClassIdW-1:0] class_id;
  } in_item_t;

  typedef struct packed {
    logic            granted;
    refusal_e        refusal;
    logic            all_done;
    logic [CntW-1:0] total_issued;
    logic [CntW-1:0] active_now;
    logic [CntW-1:0] class_issued;
  } out_item_t;

  // Saturating increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

  // Saturating subtract, floor at zero
  function automatic logic [CntW-1:0] sat_sub(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    sat_sub = (a > b) ? (a - b) : '0;
  endfunction

endpackage

`default_nettype wire

### rtl/quota_admission_controller.sv
// Quota admission controller.
// Input channel (in_valid_i / in_stall_o, payload in_data_i) carries one
// command per transfer: request a grant, release one active grant, or reset
// the counters of one class. Every command yields exactly one result on the
// output channel (out_valid_o / out_stall_i, payload out_data_o): grant flag,
// refusal reason, the one-time all_done pulse and the counters after the
// command. Refusal checks run in order: lifetime total, active count, quota.
// The command lands in an input register at the transfer edge, then one pass
// of compare and saturating add/subtract logic updates the counters and loads
// the result register once the result side does not stall. Throughput is one
// command per cycle while the receiver does not stall; the state counters are
// read and written in that single pass, so consecutive commands never wait on
// each other.
// When the receiver stalls, the result register holds and the input register
// fills; with both full, in_stall_o rises in the same cycle.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and must
// only be issued while no command is in flight; index 7 is ignored.
// Reset clears all counters, limits, the done flag and both valid bits.
`default_nettype none

module quota_admission_controller (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire qac_pkg::in_item_t        in_data_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      qac_pkg::out_item_t       out_data_o,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [qac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [qac_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [qac_pkg::CntW-1:0]       max_active_q;
  logic [qac_pkg::CntW-1:0]       max_total_q;
  logic [qac_pkg::ClassSlots-1:0] class_en_q;
  logic [qac_pkg::CntW-1:0]       class_limit_q [qac_pkg::ClassSlots];

  // Counter state
  logic [qac_pkg::CntW-1:0] total_q, total_d;
  logic [qac_pkg::CntW-1:0] active_q, active_d;
  logic [qac_pkg::CntW-1:0] cls_issued_q [qac_pkg::ClassSlots];
  logic [qac_pkg::CntW-1:0] cls_active_q [qac_pkg::ClassSlots];
  logic [qac_pkg::CntW-1:0] cls_issued_d;
  logic [qac_pkg::CntW-1:0] cls_active_d;
  logic                     done_q, done_d;

  // Pipeline registers
  logic               in_vld_q;
  qac_pkg::in_item_t  in_item_q;
  logic               out_vld_q;
  qac_pkg::out_item_t out_item_q, out_item_d;

  logic                         advance;
  logic                         process;
  logic                         cls_ok;
  logic [qac_pkg::ClassIdW-1:0] cls;
  logic [qac_pkg::CntW-1:0]     cur_issued;
  logic [qac_pkg::CntW-1:0]     cur_active;
  logic [qac_pkg::CntW-1:0]     cfg_data16;
  logic [qac_pkg::ClassSlots-1:0] cfg_data_en;

  // Handshake control
  assign advance     = !out_vld_q || !out_stall_i;
  assign process     = in_vld_q && advance;
  assign in_stall_o  = in_vld_q && !advance;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  assign cfg_data16  = cfg_data_i[qac_pkg::CntW-1:0];
  assign cfg_data_en = cfg_data_i[qac_pkg::ClassSlots-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_active_q <= '0;
      max_total_q  <= '0;
      class_en_q   <= '0;
      for (int i = 0; i < qac_pkg::ClassSlots; i++) begin
        class_limit_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qac_pkg::CfgMaxActive:   max_active_q     <= cfg_data16;
        qac_pkg::CfgMaxTotal:    max_total_q      <= cfg_data16;
        qac_pkg::CfgClassEnable: class_en_q       <= cfg_data_en;
        qac_pkg::CfgClassLimit0: class_limit_q[0] <= cfg_data16;
        qac_pkg::CfgClassLimit1: class_limit_q[1] <= cfg_data16;
        qac_pkg::CfgClassLimit2: class_limit_q[2] <= cfg_data16;
        qac_pkg::CfgClassLimit3: class_limit_q[3] <= cfg_data16;
        default: ;
      endcase
    end
  end

  // Evaluate the held command against the counters
  assign cls        = in_item_q.class_id;
  assign cls_ok     = int'(cls) < qac_pkg::NumClasses;
  assign cur_issued = cls_issued_q[cls];
  assign cur_active = cls_active_q[cls];

  always_comb begin
    total_d      = total_q;
    active_d     = active_q;
    cls_issued_d = cur_issued;
    cls_active_d = cur_active;
    done_d       = done_q;
    out_item_d   = '0;
    out_item_d.refusal = qac_pkg::RefNone;
    if (cls_ok) begin
      unique case (in_item_q.kind)
        qac_pkg::KindRequest: begin
          priority if (total_q >= max_total_q) begin
            out_item_d.refusal = qac_pkg::RefTotal;
          end else if (active_q >= max_active_q) begin
            out_item_d.refusal = qac_pkg::RefActive;
          end else if (class_en_q[cls] && (cur_issued >= class_limit_q[cls])) begin
            out_item_d.refusal = qac_pkg::RefClass;
          end else begin
            out_item_d.granted = 1'b1;
            total_d      = qac_pkg::sat_inc(total_q);
            active_d     = qac_pkg::sat_inc(active_q);
            cls_issued_d = qac_pkg::sat_inc(cur_issued);
            cls_active_d = qac_pkg::sat_inc(cur_active);
          end
        end
        qac_pkg::KindRelease: begin
          active_d     = qac_pkg::sat_sub(active_q, qac_pkg::CntW'(1));
          cls_active_d = qac_pkg::sat_sub(cur_active, qac_pkg::CntW'(1));
          if (!done_q && (total_q >= max_total_q) && (active_d == '0)) begin
            done_d              = 1'b1;
            out_item_d.all_done = 1'b1;
          end
        end
        qac_pkg::KindClassReset: begin
          total_d      = qac_pkg::sat_sub(total_q, cur_issued);
          active_d     = qac_pkg::sat_sub(active_q, cur_active);
          cls_issued_d = '0;
          cls_active_d = '0;
        end
        default: ;
      endcase
      out_item_d.class_issued = cls_issued_d;
    end
    out_item_d.total_issued = total_d;
    out_item_d.active_now   = active_d;
  end

  // Commit counter state when the command moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      active_q <= '0;
      done_q   <= 1'b0;
      for (int i = 0; i < qac_pkg::ClassSlots; i++) begin
        cls_issued_q[i] <= '0;
        cls_active_q[i] <= '0;
      end
    end else if (process) begin
      total_q           <= total_d;
      active_q          <= active_d;
      done_q            <= done_d;
      cls_issued_q[cls] <= cls_issued_d;
      cls_active_q[cls] <= cls_active_d;
    end
  end

  // Valid bits of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
    if (process) begin
      out_item_q <= out_item_d;
    end
  end

  // Done flag never clears once set
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> done_q)
    else $error("done flag cleared");

  // A grant carries no refusal reason
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.granted) |-> (out_item_q.refusal == qac_pkg::RefNone))
    else $error("grant with refusal");

  // all_done pulse only with nothing active and the done flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.all_done) |-> (out_item_q.active_now == '0) && done_q)
    else $error("all_done with active grants");

  // A result held under stall blocks the state update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> $stable(total_q) && $stable(active_q))
    else $error("counters moved while result stalled");

endmodule

`default_nettype wire

### tb/qac_checker.sv
`timescale 1ns / 100ps

module qac_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  qac_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  qac_pkg::out_item_t           out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [qac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qac_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  // Keep the print volume bounded when the block is badly broken
  localparam int PrintCap = 200;

  // Shadow copy of the limit registers
  logic [qac_pkg::CntW-1:0]       lim_active;
  logic [qac_pkg::CntW-1:0]       lim_total;
  logic [qac_pkg::NumClasses-1:0] class_en;
  logic [qac_pkg::CntW-1:0]       class_lim [qac_pkg::NumClasses];

  // Shadow copy of the admission counters
  logic [qac_pkg::CntW-1:0] total_cnt;
  logic [qac_pkg::CntW-1:0] active_cnt;
  logic [qac_pkg::CntW-1:0] cls_issued [qac_pkg::NumClasses];
  logic [qac_pkg::CntW-1:0] cls_active [qac_pkg::NumClasses];
  logic                     done_seen;

  // Verdicts predicted for accepted commands, oldest first
  qac_pkg::out_item_t verdict_q[$];
  int                 mismatches;

  function automatic logic [qac_pkg::CntW-1:0] bump(input logic [qac_pkg::CntW-1:0] v);
    return (v == qac_pkg::CntMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [qac_pkg::CntW-1:0] floor_sub(
    input logic [qac_pkg::CntW-1:0] a,
    input logic [qac_pkg::CntW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintCap) $display("%0t qac_checker: %s", $realtime, what);
  endtask

  // Apply one command to the shadow counters and return its verdict
  task automatic decide_admission(input qac_pkg::in_item_t cmd,
                                  output qac_pkg::out_item_t res);
    int c;
    c = int'(cmd.class_id);
    res = '0;
    res.refusal = qac_pkg::RefNone;
    if (c < qac_pkg::NumClasses) begin
      case (cmd.kind)
        qac_pkg::KindRequest: begin
          // Check limits in order: lifetime total, active, class quota
          if (total_cnt >= lim_total) begin
            res.refusal = qac_pkg::RefTotal;
          end else if (active_cnt >= lim_active) begin
            res.refusal = qac_pkg::RefActive;
          end else if (class_en[c] && cls_issued[c] >= class_lim[c]) begin
            res.refusal = qac_pkg::RefClass;
          end else begin
            res.granted   = 1'b1;
            total_cnt     = bump(total_cnt);
            active_cnt    = bump(active_cnt);
            cls_issued[c] = bump(cls_issued[c]);
            cls_active[c] = bump(cls_active[c]);
          end
        end
        qac_pkg::KindRelease: begin
          active_cnt    = floor_sub(active_cnt, qac_pkg::CntW'(1));
          cls_active[c] = floor_sub(cls_active[c], qac_pkg::CntW'(1));
          // Fire the done pulse once per lifetime
          if (!done_seen && total_cnt >= lim_total && active_cnt == '0) begin
            done_seen    = 1'b1;
            res.all_done = 1'b1;
          end
        end
        qac_pkg::KindClassReset: begin
          total_cnt     = floor_sub(total_cnt, cls_issued[c]);
          active_cnt    = floor_sub(active_cnt, cls_active[c]);
          cls_issued[c] = '0;
          cls_active[c] = '0;
        end
        default: ;
      endcase
      res.class_issued = cls_issued[c];
    end
    res.total_issued = total_cnt;
    res.active_now   = active_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    qac_pkg::out_item_t want;
    qac_pkg::out_item_t got;
    if (!rst_ni) begin
      lim_active = '0;
      lim_total  = '0;
      class_en   = '0;
      total_cnt  = '0;
      active_cnt = '0;
      done_seen  = 1'b0;
      for (int i = 0; i < qac_pkg::NumClasses; i++) begin
        class_lim[i]  = '0;
        cls_issued[i] = '0;
        cls_active[i] = '0;
      end
      verdict_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          qac_pkg::CfgMaxActive:   lim_active   = cfg_data_i;
          qac_pkg::CfgMaxTotal:    lim_total    = cfg_data_i;
          qac_pkg::CfgClassEnable: class_en     = cfg_data_i[qac_pkg::NumClasses-1:0];
          qac_pkg::CfgClassLimit0: class_lim[0] = cfg_data_i;
          qac_pkg::CfgClassLimit1: class_lim[1] = cfg_data_i;
          qac_pkg::CfgClassLimit2: class_lim[2] = cfg_data_i;
          qac_pkg::CfgClassLimit3: class_lim[3] = cfg_data_i;
          default: ;
        endcase
      end

      // Predict each accepted command
      if (in_valid_i && !in_stall_i) begin
        decide_admission(in_data_i, want);
        verdict_q.push_back(want);
      end

      // Compare each result transfer against the oldest verdict
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result with no command pending: %h", got));
        end else begin
          want = verdict_q.pop_front();
          if (got.granted !== want.granted)
            report_mismatch($sformatf("granted got %h want %h", got.granted, want.granted));
          if (got.refusal !== want.refusal)
            report_mismatch($sformatf("refusal got %h want %h", got.refusal, want.refusal));
          if (got.all_done !== want.all_done)
            report_mismatch($sformatf("all_done got %h want %h", got.all_done,
                                      want.all_done));
          if (got.total_issued !== want.total_issued)
            report_mismatch($sformatf("total_issued got %0d want %0d", got.total_issued,
                                      want.total_issued));
          if (got.active_now !== want.active_now)
            report_mismatch($sformatf("active_now got %0d want %0d", got.active_now,
                                      want.active_now));
          if (got.class_issued !== want.class_issued)
            report_mismatch($sformatf("class_issued got %0d want %0d", got.class_issued,
                                      want.class_issued));
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Codes the package leaves unnamed
  localparam logic [1:0]                 KindUnused  = 2'd3;
  localparam logic [qac_pkg::CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 144;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  qac_pkg::in_item_t            in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  qac_pkg::out_item_t           out_data_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [qac_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [qac_pkg::CfgDataW-1:0] cfg_data_i;

  int fail_count;
  int pending;
  bit steady;

  quota_admission_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  qac_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Give up long after the slowest legal run would have finished
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Stall the result side for a random number of cycles per transfer
  initial begin : result_stall
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic qac_pkg::in_item_t make_cmd(input logic [1:0] k, input int c);
    make_cmd.kind     = qac_pkg::kind_e'(k);
    make_cmd.class_id = c[qac_pkg::ClassIdW-1:0];
  endfunction

  function automatic qac_pkg::in_item_t random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)      return make_cmd(qac_pkg::KindRequest, $urandom_range(0, 3));
    else if (r < 80) return make_cmd(qac_pkg::KindRelease, $urandom_range(0, 3));
    else if (r < 94) return make_cmd(qac_pkg::KindClassReset, $urandom_range(0, 3));
    else             return make_cmd(KindUnused, $urandom_range(0, 3));
  endfunction

  // Hold valid until the command transfers; leave it high for the next one
  task automatic send_cmd(input qac_pkg::in_item_t cmd);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [qac_pkg::CfgIdxW-1:0] idx,
                           input logic [qac_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Write every limit register, plus the unused index
  task automatic program_limits(input logic [qac_pkg::CntW-1:0] act,
                                input logic [qac_pkg::CntW-1:0] tot,
                                input logic [3:0] en,
                                input logic [qac_pkg::CntW-1:0] l0,
                                input logic [qac_pkg::CntW-1:0] l1,
                                input logic [qac_pkg::CntW-1:0] l2,
                                input logic [qac_pkg::CntW-1:0] l3);
    logic [11:0] junk;
    junk = 12'($urandom);
    write_reg(qac_pkg::CfgMaxActive, act);
    write_reg(qac_pkg::CfgMaxTotal, tot);
    write_reg(qac_pkg::CfgClassEnable, {junk, en});
    write_reg(qac_pkg::CfgClassLimit0, l0);
    write_reg(qac_pkg::CfgClassLimit1, l1);
    write_reg(qac_pkg::CfgClassLimit2, l2);
    write_reg(qac_pkg::CfgClassLimit3, l3);
    write_reg(CfgIdxSpare, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    qac_pkg::in_item_t directed [$];
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    steady = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small limits so every refusal reason and the done pulse show up early
    program_limits(16'd3, 16'd6, 4'b0101, 16'd2, 16'd0, 16'd1, qac_pkg::CntMax);
    directed = '{
      make_cmd(qac_pkg::KindRequest, 0), make_cmd(qac_pkg::KindRequest, 0),
      make_cmd(qac_pkg::KindRequest, 0), make_cmd(qac_pkg::KindRequest, 1),
      make_cmd(qac_pkg::KindRequest, 3), make_cmd(qac_pkg::KindRelease, 1),
      make_cmd(qac_pkg::KindRequest, 2), make_cmd(qac_pkg::KindRelease, 0),
      make_cmd(qac_pkg::KindRequest, 2), make_cmd(qac_pkg::KindClassReset, 0),
      make_cmd(KindUnused, 1), make_cmd(qac_pkg::KindRequest, 3),
      make_cmd(qac_pkg::KindRequest, 3), make_cmd(qac_pkg::KindRequest, 1),
      make_cmd(qac_pkg::KindRelease, 3), make_cmd(qac_pkg::KindRequest, 1),
      make_cmd(qac_pkg::KindRelease, 0), make_cmd(qac_pkg::KindRequest, 1),
      make_cmd(qac_pkg::KindRequest, 0), make_cmd(qac_pkg::KindRelease, 1),
      make_cmd(qac_pkg::KindRelease, 1), make_cmd(qac_pkg::KindRelease, 2),
      make_cmd(qac_pkg::KindRelease, 2), make_cmd(qac_pkg::KindClassReset, 3),
      make_cmd(KindUnused, 2)
    };
    foreach (directed[i]) send_cmd(directed[i]);

    // Random phases, each with its own limits
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      steady = (p == 3 || p == 5);
      case (p)
        0: program_limits(qac_pkg::CntMax, qac_pkg::CntMax, 4'h0,
                          16'd0, 16'd0, 16'd0, 16'd0);
        1: program_limits(16'd0, qac_pkg::CntMax, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
        7: program_limits(qac_pkg::CntMax, 16'd0, 4'hF, qac_pkg::CntMax,
                          qac_pkg::CntMax, qac_pkg::CntMax, qac_pkg::CntMax);
        default: program_limits(16'($urandom_range(1, 8)), 16'($urandom_range(0, 300)),
                                4'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 40)));
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Let the pipeline run dry once in the middle of a phase
        if (p == 4 && n == ItemsPerPhase / 2) drain();
        send_cmd(random_cmd());
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### quota_admission_controller.f
rtl/qac_pkg.sv
rtl/quota_admission_controller.sv
tb/qac_checker.sv
tb/tb_top.sv
